// File: rtl/trt_pkg.sv
// Shared constants, types and floating-point compare for the route tracker.
package trt_pkg;

  localparam int ROUTE_ENTRIES  = 16;
  localparam int SPECIES_COUNT  = 1024;
  localparam int REACTANT_SLOTS = 3;
  localparam int PRODUCT_SLOTS  = 4;

  localparam int RT_AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int RT_CW = $clog2(ROUTE_ENTRIES + 1);
  localparam int SP_AW = $clog2(SPECIES_COUNT);
  localparam int ROW_W = 80;

  localparam logic [7:0] KIND_FIRST_ONLY = 8'd0;
  localparam logic [7:0] KIND_RATE_ONLY  = 8'd23;

  typedef enum logic [1:0] {
    REQ_WRITE    = 2'd0,
    REQ_REACTION = 2'd1,
    REQ_CLEAR    = 2'd2,
    REQ_READOUT  = 2'd3
  } req_t;

  typedef logic [63:0] dbl_t;

  typedef struct packed {
    logic start;
    dbl_t a;
    dbl_t b;
  } fmul_req_t;

  typedef struct packed {
    logic done;
    dbl_t res;
  } fmul_rsp_t;

  function automatic logic fp_is_nan(dbl_t x);
    return (x[62:52] == 11'h7ff) && (x[51:0] != 52'd0);
  endfunction

  // IEEE a < b; false when either is NaN
  function automatic logic fp_lt(dbl_t a, dbl_t b);
    logic both_zero;
    both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    if (fp_is_nan(a) || fp_is_nan(b) || both_zero) return 1'b0;
    if (a[63] != b[63]) return a[63];
    if (!a[63]) return a[62:0] < b[62:0];
    return a[62:0] > b[62:0];
  endfunction

endpackage

// File: rtl/trt_if.sv
// Request and result channel interfaces.
interface trt_req_if;
  import trt_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [9:0]         species_index;
  logic [15:0]        rxn_num;
  logic [7:0]         reaction_kind;
  logic signed [10:0] reactant_a;
  logic signed [10:0] reactant_b;
  logic signed [10:0] reactant_c;
  logic signed [10:0] product_a;
  logic signed [10:0] product_b;
  logic signed [10:0] product_c;
  logic signed [10:0] product_d;
  dbl_t               value_bits;

  modport source (output valid, req_type, species_index, rxn_num, reaction_kind,
                  reactant_a, reactant_b, reactant_c, product_a, product_b, product_c,
                  product_d, value_bits, input ready);
  modport sink (input valid, req_type, species_index, rxn_num, reaction_kind,
                reactant_a, reactant_b, reactant_c, product_a, product_b, product_c,
                product_d, value_bits, output ready);
endinterface

interface trt_res_if;
  import trt_pkg::*;
  logic        valid;
  logic        ready;
  logic [3:0]  route_slot;
  logic [15:0] formation_reaction;
  dbl_t        form_value;
  logic [15:0] destruction_reaction;
  dbl_t        dest_value;
  logic        last_of_run;

  modport source (output valid, route_slot, formation_reaction, form_value,
                  destruction_reaction, dest_value, last_of_run, input ready);
  modport sink (input valid, route_slot, formation_reaction, form_value,
                destruction_reaction, dest_value, last_of_run, output ready);
endinterface

// File: rtl/trt_ram.sv
// Generic single-port-write, registered-read RAM.
module trt_ram #(
  parameter int W = 8,
  parameter int D = 2,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: rtl/trt_fmul.sv
// Multi-cycle IEEE double multiplier, round to nearest even.
module trt_fmul (
  input  logic                clk,
  input  logic                rst_n,
  input  trt_pkg::fmul_req_t  req,
  output trt_pkg::fmul_rsp_t  rsp
);
  import trt_pkg::*;

  typedef enum logic [4:0] {
    FM_IDLE  = 5'b00001,
    FM_PROD  = 5'b00010,
    FM_LZC   = 5'b00100,
    FM_ALIGN = 5'b01000,
    FM_ROUND = 5'b10000
  } fm_state_t;

  function automatic logic [6:0] lzc106(logic [105:0] v);
    logic [6:0] n;
    n = 7'd106;
    for (int i = 0; i < 106; i++) if (v[i]) n = 7'(105 - i);
    return n;
  endfunction

  fm_state_t          st_r, st_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [52:0]        ma_r, ma_nxt, mb_r, mb_nxt;
  logic               sgn_r, sgn_nxt;
  logic [11:0]        esum_r, esum_nxt;
  logic [105:0]       acc_r, acc_nxt;
  logic [6:0]         lz_r, lz_nxt;
  logic [105:0]       pn_r, pn_nxt;
  logic signed [13:0] e_r, e_nxt;
  dbl_t               res_r, res_nxt;
  logic               done_r, done_nxt;

  logic [10:0]  ea, eb;
  logic         a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic [26:0]  a_part, b_part;
  logic [53:0]  pp;
  logic [6:0]   pp_sh, shv;
  logic [105:0] q;
  logic         sticky_lo, g, stk, rnd;
  logic [52:0]  mant;
  logic [10:0]  ef;
  logic [62:0]  sum;

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    sgn_nxt  = sgn_r;
    esum_nxt = esum_r;
    acc_nxt  = acc_r;
    lz_nxt   = lz_r;
    pn_nxt   = pn_r;
    e_nxt    = e_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;

    ea     = req.a[62:52];
    eb     = req.b[62:52];
    a_nan  = fp_is_nan(req.a);
    b_nan  = fp_is_nan(req.b);
    a_inf  = (ea == 11'h7ff) && (req.a[51:0] == 52'd0);
    b_inf  = (eb == 11'h7ff) && (req.b[51:0] == 52'd0);
    a_zero = req.a[62:0] == 63'd0;
    b_zero = req.b[62:0] == 63'd0;
    sgn    = req.a[63] ^ req.b[63];

    a_part = cnt_r[1] ? ma_r[52:26] : {1'b0, ma_r[25:0]};
    b_part = cnt_r[0] ? mb_r[52:26] : {1'b0, mb_r[25:0]};
    pp     = a_part * b_part;
    pp_sh  = (cnt_r[1] ? 7'd26 : 7'd0) + (cnt_r[0] ? 7'd26 : 7'd0);

    // subnormal right shift and rounding
    shv       = (e_r < -14'sd104) ? 7'd106 : 7'(14'sd1 - e_r);
    q         = pn_r;
    sticky_lo = 1'b0;
    ef        = e_r[10:0];
    if (e_r < 14'sd1) begin
      q         = pn_r >> shv;
      sticky_lo = |(pn_r & ~({106{1'b1}} << shv));
      ef        = 11'd0;
    end
    mant = q[105:53];
    g    = q[52];
    stk  = (|q[51:0]) | sticky_lo;
    rnd  = g & (mant[0] | stk);
    sum  = {ef, mant[51:0]} + 63'(rnd);

    case (st_r)
      FM_IDLE: begin
        if (req.start) begin
          if (a_nan) begin
            res_nxt  = req.a | 64'h0008_0000_0000_0000;
            done_nxt = 1'b1;
          end else if (b_nan) begin
            res_nxt  = req.b | 64'h0008_0000_0000_0000;
            done_nxt = 1'b1;
          end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            res_nxt  = 64'hfff8_0000_0000_0000;
            done_nxt = 1'b1;
          end else if (a_inf || b_inf) begin
            res_nxt  = {sgn, 11'h7ff, 52'd0};
            done_nxt = 1'b1;
          end else if (a_zero || b_zero) begin
            res_nxt  = {sgn, 63'd0};
            done_nxt = 1'b1;
          end else begin
            sgn_nxt  = sgn;
            ma_nxt   = {ea != 11'd0, req.a[51:0]};
            mb_nxt   = {eb != 11'd0, req.b[51:0]};
            esum_nxt = 12'((ea == 11'd0) ? 11'd1 : ea) + 12'((eb == 11'd0) ? 11'd1 : eb);
            acc_nxt  = 106'd0;
            cnt_nxt  = 2'd0;
            st_nxt   = FM_PROD;
          end
        end
      end
      FM_PROD: begin
        acc_nxt = acc_r + (106'(pp) << pp_sh);
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) st_nxt = FM_LZC;
      end
      FM_LZC: begin
        lz_nxt = lzc106(acc_r);
        st_nxt = FM_ALIGN;
      end
      FM_ALIGN: begin
        pn_nxt = acc_r << lz_r;
        e_nxt  = 14'(esum_r) - 14'd1022 - 14'(lz_r);
        st_nxt = FM_ROUND;
      end
      FM_ROUND: begin
        if (e_r > 14'sd2046) res_nxt = {sgn_r, 11'h7ff, 52'd0};
        else res_nxt = {sgn_r, sum};
        done_nxt = 1'b1;
        st_nxt   = FM_IDLE;
      end
      default: st_nxt = FM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= FM_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    sgn_r  <= sgn_nxt;
    esum_r <= esum_nxt;
    acc_r  <= acc_nxt;
    lz_r   <= lz_nxt;
    pn_r   <= pn_nxt;
    e_r    <= e_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;
endmodule

// File: rtl/top_reaction_route_tracker.sv
// Reaction route tracker: abundance store, rate multiply and top-K route tables.
// Tracked reaction: each kept reactant adds a store read and a multiply (shorter on a zero
// or special operand), then a scan of the tables. Write, clear and untracked reaction
// finish in the idle state; readout steps each entry through issue, wait and hold states.
// One request at a time. Synchronous active-low reset clears control state,
// the tracked species and the route-table valid bits; the abundance store is not reset.
module top_reaction_route_tracker (
  input  logic        clk,
  input  logic        rst_n,
  trt_req_if.sink     in_ch,
  trt_res_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_data
);
  import trt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FSEL   = 9'b000000010,
    S_FRD    = 9'b000000100,
    S_FWAIT  = 9'b000001000,
    S_SCAN   = 9'b000010000,
    S_UPD    = 9'b000100000,
    S_RISSUE = 9'b001000000,
    S_RWAIT  = 9'b010000000,
    S_RHOLD  = 9'b100000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [9:0]               trk_r;
  logic [ROUTE_ENTRIES-1:0] fv_r, fv_nxt, dv_r, dv_nxt;
  logic [15:0]              num_r, num_nxt;
  dbl_t                     rate_r, rate_nxt;
  logic [2:0]               fmask_r, fmask_nxt;
  logic [SP_AW-1:0]         reac_r [3];
  logic [SP_AW-1:0]         reac_nxt [3];
  logic                     in_prod_r, in_prod_nxt, in_reac_r, in_reac_nxt;
  logic [RT_CW-1:0]         cnt_r, cnt_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic [RT_AW-1:0]         rd_idx_r, rd_idx_nxt;
  dbl_t                     fmin_r, fmin_nxt, dmin_r, dmin_nxt;
  logic [RT_AW-1:0]         fidx_r, fidx_nxt, didx_r, didx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [3:0]               o_slot_r, o_slot_nxt;
  logic [15:0]              o_fnum_r, o_fnum_nxt, o_dnum_r, o_dnum_nxt;
  dbl_t                     o_frate_r, o_frate_nxt, o_drate_r, o_drate_nxt;
  logic                     o_last_r, o_last_nxt;

  logic signed [10:0] reac_in [3];
  logic signed [10:0] prod_in [4];
  logic [2:0]         vmask, mask_in;
  logic               hit_prod, hit_reac, accept;
  logic [1:0]         fsel;

  logic               ab_we;
  logic [SP_AW-1:0]   ab_raddr;
  dbl_t               ab_rdata;
  logic               f_we, d_we;
  logic [RT_AW-1:0]   rt_raddr;
  logic [ROW_W-1:0]   f_rdata, d_rdata;
  dbl_t               f_ent, d_ent;
  logic [15:0]        f_ent_num, d_ent_num;

  fmul_req_t mreq;
  fmul_rsp_t mrsp;

  assign accept = in_ch.valid && (state_r == S_IDLE);
  assign reac_in[0] = in_ch.reactant_a;
  assign reac_in[1] = in_ch.reactant_b;
  assign reac_in[2] = in_ch.reactant_c;
  assign prod_in[0] = in_ch.product_a;
  assign prod_in[1] = in_ch.product_b;
  assign prod_in[2] = in_ch.product_c;
  assign prod_in[3] = in_ch.product_d;

  always_comb begin
    hit_prod = 1'b0;
    hit_reac = 1'b0;
    vmask    = 3'd0;
    for (int i = 0; i < PRODUCT_SLOTS; i++)
      if (prod_in[i] == {1'b0, trk_r}) hit_prod = 1'b1;
    for (int i = 0; i < REACTANT_SLOTS; i++) begin
      if (reac_in[i] == {1'b0, trk_r}) hit_reac = 1'b1;
      vmask[i] = !reac_in[i][10] && ({1'b0, reac_in[i][9:0]} < 11'(SPECIES_COUNT));
    end
    case (in_ch.reaction_kind)
      KIND_FIRST_ONLY: mask_in = {2'b00, vmask[0]};
      KIND_RATE_ONLY:  mask_in = 3'd0;
      default:         mask_in = vmask;
    endcase
  end

  always_comb begin
    if (fmask_r[0])      fsel = 2'd0;
    else if (fmask_r[1]) fsel = 2'd1;
    else                 fsel = 2'd2;
  end

  assign ab_we    = accept && (in_ch.req_type == REQ_WRITE) &&
                    ({1'b0, in_ch.species_index} < 11'(SPECIES_COUNT));
  assign ab_raddr = reac_r[fsel];

  trt_ram #(.W(64), .D(SPECIES_COUNT)) u_abund (
    .clk(clk), .we(ab_we), .waddr(in_ch.species_index[SP_AW-1:0]),
    .wdata(in_ch.value_bits), .raddr(ab_raddr), .rdata(ab_rdata)
  );

  assign rt_raddr = cnt_r[RT_AW-1:0];
  assign f_we = (state_r == S_UPD) && in_prod_r && fp_lt(fmin_r, rate_r);
  assign d_we = (state_r == S_UPD) && in_reac_r && fp_lt(dmin_r, rate_r);

  trt_ram #(.W(ROW_W), .D(ROUTE_ENTRIES)) u_form (
    .clk(clk), .we(f_we), .waddr(fidx_r), .wdata({num_r, rate_r}),
    .raddr(rt_raddr), .rdata(f_rdata)
  );

  trt_ram #(.W(ROW_W), .D(ROUTE_ENTRIES)) u_dest (
    .clk(clk), .we(d_we), .waddr(didx_r), .wdata({num_r, rate_r}),
    .raddr(rt_raddr), .rdata(d_rdata)
  );

  // entries never written since the last clear read as zero
  assign f_ent     = fv_r[rd_idx_r] ? f_rdata[63:0]  : 64'd0;
  assign f_ent_num = fv_r[rd_idx_r] ? f_rdata[79:64] : 16'd0;
  assign d_ent     = dv_r[rd_idx_r] ? d_rdata[63:0]  : 64'd0;
  assign d_ent_num = dv_r[rd_idx_r] ? d_rdata[79:64] : 16'd0;

  assign mreq.start = (state_r == S_FRD);
  assign mreq.a     = rate_r;
  assign mreq.b     = ab_rdata;

  trt_fmul u_fmul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  always_comb begin
    state_nxt     = state_r;
    fv_nxt        = fv_r;
    dv_nxt        = dv_r;
    num_nxt       = num_r;
    rate_nxt      = rate_r;
    fmask_nxt     = fmask_r;
    reac_nxt      = reac_r;
    in_prod_nxt   = in_prod_r;
    in_reac_nxt   = in_reac_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    fmin_nxt      = fmin_r;
    dmin_nxt      = dmin_r;
    fidx_nxt      = fidx_r;
    didx_nxt      = didx_r;
    out_valid_nxt = out_valid_r;
    o_slot_nxt    = o_slot_r;
    o_fnum_nxt    = o_fnum_r;
    o_dnum_nxt    = o_dnum_r;
    o_frate_nxt   = o_frate_r;
    o_drate_nxt   = o_drate_r;
    o_last_nxt    = o_last_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.req_type)
            REQ_CLEAR: begin
              fv_nxt = '0;
              dv_nxt = '0;
            end
            REQ_READOUT: begin
              cnt_nxt   = '0;
              state_nxt = S_RISSUE;
            end
            REQ_REACTION: begin
              num_nxt     = in_ch.rxn_num;
              rate_nxt    = in_ch.value_bits;
              fmask_nxt   = mask_in;
              in_prod_nxt = hit_prod;
              in_reac_nxt = hit_reac;
              for (int i = 0; i < 3; i++) reac_nxt[i] = reac_in[i][SP_AW-1:0];
              if (hit_prod || hit_reac) state_nxt = S_FSEL;
            end
            default: ;
          endcase
        end
      end
      S_FSEL: begin
        if (fmask_r == 3'd0) begin
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end else begin
          fmask_nxt[fsel] = 1'b0;
          state_nxt       = S_FRD;
        end
      end
      S_FRD: state_nxt = S_FWAIT;
      S_FWAIT: begin
        if (mrsp.done) begin
          rate_nxt  = mrsp.res;
          state_nxt = S_FSEL;
        end
      end
      S_SCAN: begin
        if (cnt_r != RT_CW'(ROUTE_ENTRIES)) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[RT_AW-1:0];
          cnt_nxt    = cnt_r + RT_CW'(1);
        end else begin
          state_nxt = S_UPD;
        end
        if (rd_vld_r) begin
          if ((rd_idx_r == '0) || fp_lt(f_ent, fmin_r)) begin
            fmin_nxt = f_ent;
            fidx_nxt = rd_idx_r;
          end
          if ((rd_idx_r == '0) || fp_lt(d_ent, dmin_r)) begin
            dmin_nxt = d_ent;
            didx_nxt = rd_idx_r;
          end
        end
      end
      S_UPD: begin
        if (f_we) fv_nxt[fidx_r] = 1'b1;
        if (d_we) dv_nxt[didx_r] = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RISSUE: begin
        rd_idx_nxt = cnt_r[RT_AW-1:0];
        state_nxt  = S_RWAIT;
      end
      S_RWAIT: begin
        out_valid_nxt = 1'b1;
        o_slot_nxt    = 4'(cnt_r);
        o_fnum_nxt    = f_ent_num;
        o_frate_nxt   = f_ent;
        o_dnum_nxt    = d_ent_num;
        o_drate_nxt   = d_ent;
        o_last_nxt    = cnt_r == RT_CW'(ROUTE_ENTRIES - 1);
        state_nxt     = S_RHOLD;
      end
      S_RHOLD: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (o_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + RT_CW'(1);
            state_nxt = S_RISSUE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      trk_r       <= 10'd0;
      fv_r        <= '0;
      dv_r        <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) trk_r <= cfg_data;
      fv_r        <= fv_nxt;
      dv_r        <= dv_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r     <= num_nxt;
    rate_r    <= rate_nxt;
    fmask_r   <= fmask_nxt;
    reac_r    <= reac_nxt;
    in_prod_r <= in_prod_nxt;
    in_reac_r <= in_reac_nxt;
    cnt_r     <= cnt_nxt;
    rd_idx_r  <= rd_idx_nxt;
    fmin_r    <= fmin_nxt;
    dmin_r    <= dmin_nxt;
    fidx_r    <= fidx_nxt;
    didx_r    <= didx_nxt;
    o_slot_r  <= o_slot_nxt;
    o_fnum_r  <= o_fnum_nxt;
    o_dnum_r  <= o_dnum_nxt;
    o_frate_r <= o_frate_nxt;
    o_drate_r <= o_drate_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign in_ch.ready                 = (state_r == S_IDLE);
  assign out_ch.valid                = out_valid_r;
  assign out_ch.route_slot           = o_slot_r;
  assign out_ch.formation_reaction   = o_fnum_r;
  assign out_ch.form_value           = o_frate_r;
  assign out_ch.destruction_reaction = o_dnum_r;
  assign out_ch.dest_value           = o_drate_r;
  assign out_ch.last_of_run          = o_last_r;
endmodule

// File: rtl/trt_checker.sv
// Port-level assertions for the route tracker, bound to the top level.
module trt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_route_slot,
  input logic [63:0] out_form_value,
  input logic        out_last_of_run
);
  import trt_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_route_slot) &&
    $stable(out_form_value))
    else $error("result changed while stalled");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_of_run == (out_route_slot == 4'(ROUTE_ENTRIES - 1))))
    else $error("last flag on wrong slot");

  a_busy_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken during readout");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_of_run |=> !out_valid)
    else $error("result after end of run");
endmodule

bind top_reaction_route_tracker trt_checker u_trt_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_route_slot(out_ch.route_slot),
  .out_form_value(out_ch.form_value),
  .out_last_of_run(out_ch.last_of_run)
);

// File: tb/tb_top_reaction_route_tracker.sv
// Self-checking testbench for the reaction route tracker: top-K formation and destruction tables.
`timescale 1ns / 1ps
module tb_top_reaction_route_tracker;
  import trt_pkg::*;

  typedef struct packed {
    req_t               req;
    logic [9:0]         species;
    logic [15:0]        number;
    logic [7:0]         kind;
    logic signed [10:0] ra, rb, rc;
    logic signed [10:0] pa, pb, pc, pd;
    dbl_t               value;
  } route_req_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [15:0] f_num;
    dbl_t        f_rate;
    logic [15:0] d_num;
    dbl_t        d_rate;
    logic        last;
  } route_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [9:0] cfg_data = '0;

  trt_req_if in_ch ();
  trt_res_if out_ch ();

  top_reaction_route_tracker i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // predictor state
  logic [9:0]  tracked;
  real         abundance [SPECIES_COUNT];
  real         form_rate [ROUTE_ENTRIES];
  logic [15:0] form_num  [ROUTE_ENTRIES];
  real         dest_rate [ROUTE_ENTRIES];
  logic [15:0] dest_num  [ROUTE_ENTRIES];
  int          written_q [$];
  bit          written   [SPECIES_COUNT];

  route_row_t  expected_rows [$];
  int          mismatches = 0;
  int          requests_sent = 0;
  int          rows_checked = 0;
  int          readouts_sent = 0;
  bit          gaps_on = 1'b1;
  int          hold_request = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Timeout at %0t", $time);
    $display("Mismatches found");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        hold--;
      end else if (!gaps_on) out_ch.ready = 1'b1;
      else out_ch.ready = (gap_len() == 0);
    end
  end

  task automatic clear_routes();
    for (int i = 0; i < ROUTE_ENTRIES; i++) begin
      form_rate[i] = 0.0; form_num[i] = '0;
      dest_rate[i] = 0.0; dest_num[i] = '0;
    end
  endtask

  task automatic offer_route(ref real rates[ROUTE_ENTRIES], ref logic [15:0] nums[ROUTE_ENTRIES],
                             input real rate, input logic [15:0] num);
    real lo;
    int  at;
    lo = rates[0];
    at = 0;
    for (int l = 1; l < ROUTE_ENTRIES; l++)
      if (rates[l] < lo) begin
        lo = rates[l];
        at = l;
      end
    if (rate > lo) begin
      rates[at] = rate;
      nums[at] = num;
    end
  endtask

  task automatic predict_routes(input route_req_t r);
    int   reac [3];
    int   prod [4];
    bit   is_prod, is_reac;
    real  rate;
    route_row_t row;
    case (r.req)
      REQ_WRITE: abundance[r.species] = $bitstoreal(r.value);
      REQ_CLEAR: clear_routes();
      REQ_READOUT: begin
        for (int i = 0; i < ROUTE_ENTRIES; i++) begin
          row.slot = i[3:0];
          row.f_num = form_num[i];
          row.f_rate = $realtobits(form_rate[i]);
          row.d_num = dest_num[i];
          row.d_rate = $realtobits(dest_rate[i]);
          row.last = (i == ROUTE_ENTRIES - 1);
          expected_rows.push_back(row);
        end
      end
      default: begin
        reac = '{int'(r.ra), int'(r.rb), int'(r.rc)};
        prod = '{int'(r.pa), int'(r.pb), int'(r.pc), int'(r.pd)};
        is_prod = 0;
        is_reac = 0;
        for (int i = 0; i < PRODUCT_SLOTS; i++) if (prod[i] == int'(tracked)) is_prod = 1;
        for (int i = 0; i < REACTANT_SLOTS; i++) if (reac[i] == int'(tracked)) is_reac = 1;
        rate = $bitstoreal(r.value);
        if (r.kind == KIND_FIRST_ONLY) begin
          if (reac[0] >= 0) rate = rate * abundance[reac[0]];
        end else if (r.kind != KIND_RATE_ONLY) begin
          for (int i = 0; i < REACTANT_SLOTS; i++)
            if (reac[i] >= 0) rate = rate * abundance[reac[i]];
        end
        if (is_prod) offer_route(form_rate, form_num, rate, r.number);
        if (is_reac) offer_route(dest_rate, dest_num, rate, r.number);
      end
    endcase
  endtask

  task automatic send_req(input route_req_t r);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_ch.valid = 1'b0;
      repeat (g - 1) @(negedge clk);
      @(negedge clk);
    end
    {in_ch.req_type, in_ch.species_index, in_ch.rxn_num, in_ch.reaction_kind,
     in_ch.reactant_a, in_ch.reactant_b, in_ch.reactant_c, in_ch.product_a,
     in_ch.product_b, in_ch.product_c, in_ch.product_d, in_ch.value_bits} = r;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_routes(r);
    requests_sent++;
    if (r.req == REQ_WRITE && !written[r.species]) begin
      written[r.species] = 1'b1;
      written_q.push_back(r.species);
    end
    if (r.req == REQ_READOUT) readouts_sent++;
  endtask

  // result checker
  always @(posedge clk) begin
    route_row_t got, exp_row;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.route_slot, out_ch.formation_reaction, out_ch.form_value,
             out_ch.destruction_reaction, out_ch.dest_value, out_ch.last_of_run};
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row, actual %h", $time, got);
        mismatches++;
      end else begin
        exp_row = expected_rows.pop_front();
        rows_checked++;
        if (got.slot !== exp_row.slot) begin
          $display("%0t: slot exp %0d act %0d", $time, exp_row.slot, got.slot);
          mismatches++;
        end
        if (got.f_num !== exp_row.f_num) begin
          $display("%0t: formation reaction exp %0d act %0d", $time, exp_row.f_num, got.f_num);
          mismatches++;
        end
        if (got.f_rate !== exp_row.f_rate) begin
          $display("%0t: formation rate exp %h act %h", $time, exp_row.f_rate, got.f_rate);
          mismatches++;
        end
        if (got.d_num !== exp_row.d_num) begin
          $display("%0t: destruction reaction exp %0d act %0d", $time, exp_row.d_num, got.d_num);
          mismatches++;
        end
        if (got.d_rate !== exp_row.d_rate) begin
          $display("%0t: destruction rate exp %h act %h", $time, exp_row.d_rate, got.d_rate);
          mismatches++;
        end
        if (got.last !== exp_row.last) begin
          $display("%0t: last exp %0b act %0b", $time, exp_row.last, got.last);
          mismatches++;
        end
      end
    end
  end

  // wait for the block to settle; reactions finish silently so allow their latency
  task automatic drain_block();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_tracked(input logic [9:0] v);
    drain_block();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    tracked = v;
  endtask

  function automatic dbl_t rand_dbl(input int elo, input int ehi);
    return {1'($urandom_range(0, 5) == 0), 11'($urandom_range(elo, ehi)),
            20'($urandom), 32'($urandom)};
  endfunction

  function automatic route_req_t blank_req(input req_t k);
    route_req_t r;
    r = '0;
    r.req = k;
    r.species = 10'($urandom);
    r.number = 16'($urandom);
    r.kind = 8'($urandom);
    {r.ra, r.rb, r.rc, r.pa, r.pb, r.pc, r.pd} = {7{11'h7ff}};
    r.value = {$urandom, $urandom};
    return r;
  endfunction

  function automatic route_req_t write_req(input logic [9:0] sp, input dbl_t v);
    route_req_t r;
    r = blank_req(REQ_WRITE);
    r.species = sp;
    r.value = v;
    return r;
  endfunction

  function automatic route_req_t react_req(input logic [7:0] kind, input logic [15:0] num,
                                          input int ra, rb, rc, pa, pb, pc, pd,
                                          input dbl_t v);
    route_req_t r;
    r = blank_req(REQ_REACTION);
    r.kind = kind; r.number = num; r.value = v;
    r.ra = 11'(ra); r.rb = 11'(rb); r.rc = 11'(rc);
    r.pa = 11'(pa); r.pb = 11'(pb); r.pc = 11'(pc); r.pd = 11'(pd);
    return r;
  endfunction

  // reactant: a written species, absent, or another negative index
  function automatic int pick_reactant();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && written_q.size() > 0) return written_q[$urandom_range(0, written_q.size() - 1)];
    if (r < 9) return -1;
    return -int'($urandom_range(2, 1024));
  endfunction

  function automatic int pick_product();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return int'(tracked);
    if (r < 6) return -1;
    if (r < 9) return $urandom_range(0, SPECIES_COUNT - 1);
    return -int'($urandom_range(2, 1024));
  endfunction

  function automatic route_req_t rand_reaction();
    int ra, rb, rc, pa, pb, pc, pd, k;
    logic [7:0] kind;
    ra = pick_reactant(); rb = pick_reactant(); rc = pick_reactant();
    pa = pick_product(); pb = pick_product(); pc = pick_product(); pd = pick_product();
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, 2);
      if (k == 0) ra = int'(tracked) < 0 ? ra : (written[tracked] ? int'(tracked) : ra);
      else if (k == 1 && written[tracked]) rb = int'(tracked);
      else if (written[tracked]) rc = int'(tracked);
    end
    k = $urandom_range(0, 9);
    kind = (k < 3) ? KIND_FIRST_ONLY : (k < 5) ? KIND_RATE_ONLY : 8'($urandom);
    return react_req(kind, 16'($urandom), ra, rb, rc, pa, pb, pc, pd, rand_dbl(1000, 1046));
  endfunction

  task automatic test_reset_tables();
    send_req(blank_req(REQ_READOUT));
  endtask

  task automatic test_directed_rates();
    send_req(write_req(10'd0, 64'h4000_0000_0000_0000));
    send_req(write_req(10'd1023, 64'hC008_0000_0000_0000));
    send_req(write_req(10'd5, 64'h3FE0_0000_0000_0000));
    send_req(write_req(10'd6, 64'h4010_0000_0000_0000));
    send_req(react_req(KIND_FIRST_ONLY, 16'd1, 5, 6, -1, -1, -1, -1, 0, 64'h4024_0000_0000_0000));
    send_req(react_req(KIND_RATE_ONLY, 16'd65535, 5, 6, 1023, 0, -1, -1, -1,
                       64'h3FF8_0000_0000_0000));
    send_req(react_req(8'd255, 16'd3, 5, 6, 1023, -1, -1, -1, 0, 64'h4000_0000_0000_0000));
    send_req(react_req(8'd7, 16'd4, 0, 5, -1, -1, 0, -1, -1, 64'h4020_0000_0000_0000));
    send_req(react_req(KIND_FIRST_ONLY, 16'd5, -1, 6, -1, -1, -1, 0, -1, 64'h4030_0000_0000_0000));
    send_req(react_req(KIND_RATE_ONLY, 16'd6, -1024, -2, -1, 0, -1, -1, -1, 64'h7FF8_0000_0000_0001));
    send_req(react_req(KIND_RATE_ONLY, 16'd7, 0, -1, -1, -1, -1, -1, -1, 64'h7FF0_0000_0000_0000));
    send_req(react_req(KIND_RATE_ONLY, 16'd8, 0, -1, -1, 0, -1, -1, -1, 64'hBFF0_0000_0000_0000));
    send_req(react_req(KIND_RATE_ONLY, 16'd9, -1, -1, -1, 0, -1, -1, -1, 64'h8000_0000_0000_0000));
    send_req(react_req(8'd1, 16'd10, 5, -1, -1, 1, 2, -1, -1, 64'h4000_0000_0000_0000));
    send_req(blank_req(REQ_READOUT));
    send_req(blank_req(REQ_CLEAR));
    send_req(blank_req(REQ_READOUT));
  endtask

  task automatic test_config_extremes();
    set_tracked(10'd1023);
    send_req(react_req(KIND_RATE_ONLY, 16'd11, 1023, -1, -1, 1023, -1, -1, -1,
                       64'h4000_0000_0000_0000));
    send_req(react_req(8'd2, 16'd12, 5, 6, 1023, -1, -1, -1, 1023, 64'h3FF0_0000_0000_0000));
    send_req(blank_req(REQ_READOUT));
  endtask

  task automatic test_random_mix(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      if (n % 25 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (n % 40 == 39) set_tracked(($urandom_range(0, 2) == 0) ? 10'd0 : 10'($urandom));
      r = $urandom_range(0, 99);
      if (r < 15) send_req(write_req(10'($urandom), rand_dbl(1003, 1043)));
      else if (r < 80) send_req(rand_reaction());
      else if (r < 85) send_req(blank_req(REQ_CLEAR));
      else send_req(blank_req(REQ_READOUT));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_output_stall();
    drain_block();
    hold_request = 300;
    repeat (4) send_req(blank_req(REQ_READOUT));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.req_type, in_ch.species_index, in_ch.rxn_num, in_ch.reaction_kind,
     in_ch.reactant_a, in_ch.reactant_b, in_ch.reactant_c, in_ch.product_a,
     in_ch.product_b, in_ch.product_c, in_ch.product_d, in_ch.value_bits} = '0;
    tracked = '0;
    clear_routes();
    for (int i = 0; i < SPECIES_COUNT; i++) begin
      abundance[i] = 0.0;
      written[i] = 1'b0;
    end
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_reset_tables();
    set_tracked(10'd0);
    test_directed_rates();
    test_config_extremes();
    set_tracked(10'd5);
    test_random_mix(130);
    test_output_stall();
    drain_block();
    $display("Sent %0d requests (%0d readouts); checked %0d table rows.",
             requests_sent, readouts_sent, rows_checked);
    $display("Covered abundance writes, all rate kinds, clears, tracking changes and output stalls.");
    if (mismatches == 0 && expected_rows.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// File: top_reaction_route_tracker.f
rtl/trt_pkg.sv
rtl/trt_if.sv
rtl/trt_ram.sv
rtl/trt_fmul.sv
rtl/top_reaction_route_tracker.sv
rtl/trt_checker.sv
tb/tb_top_reaction_route_tracker.sv
